/* sv/assert_macros.svh */
// assertion macros for the rtl files, included by kmcm_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define KMCM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define KMCM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KMCM_ASSERT(lbl, clk, rst_n, prop, msg)
`define KMCM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* sv/kmcm_pkg.sv */
`default_nettype none

package kmcm_pkg;

    localparam int ROW_LINES  = 16;
    localparam int COL_LINES  = 16;
    localparam int KEY_IDS    = 256;
    localparam int KEY_AW     = $clog2(KEY_IDS);
    localparam int SHADOW_N   = 16;
    localparam int SHADOW_AW  = $clog2(SHADOW_N);
    localparam int PADDR_W    = 4;

    // func codes
    localparam logic [2:0] FUNC_PRESS   = 3'd0;
    localparam logic [2:0] FUNC_RELEASE = 3'd1;
    localparam logic [2:0] FUNC_LOAD    = 3'd2;
    localparam logic [2:0] FUNC_CLEAR   = 3'd3;
    localparam logic [2:0] FUNC_QUERY   = 3'd4;

    // host key ids
    localparam logic [7:0] K_NONE    = 8'd0;
    localparam logic [7:0] K_RESTORE = 8'd1;
    localparam logic [7:0] K_LEFT    = 8'd2;
    localparam logic [7:0] K_UP      = 8'd3;
    localparam logic [7:0] K_RIGHT   = 8'd4;
    localparam logic [7:0] K_DOWN    = 8'd5;
    localparam logic [7:0] K_LSHIFT  = 8'd6;
    localparam logic [7:0] K_F1      = 8'd7;
    localparam logic [7:0] K_F2      = 8'd8;
    localparam logic [7:0] K_F3      = 8'd9;
    localparam logic [7:0] K_F4      = 8'd10;
    localparam logic [7:0] K_F5      = 8'd11;
    localparam logic [7:0] K_F6      = 8'd12;
    localparam logic [7:0] K_F7      = 8'd13;
    localparam logic [7:0] K_F8      = 8'd14;

    // keyboard models
    localparam logic [2:0] MODEL_CURSOR_A = 3'd1;
    localparam logic [2:0] MODEL_CURSOR_B = 3'd2;
    localparam logic [2:0] MODEL_ALT_FKEY = 3'd4;

    // register indexes and reset values
    localparam logic [1:0] REG_MODEL = 2'd0;
    localparam logic [1:0] REG_ROWS  = 2'd1;
    localparam logic [1:0] REG_COLS  = 2'd2;
    localparam logic [2:0] RST_MODEL = 3'd1;
    localparam logic [4:0] RST_ROWS  = 5'd8;
    localparam logic [4:0] RST_COLS  = 5'd8;

    localparam logic [3:0] COL_SPLIT = 4'd8;
    localparam logic [3:0] COL_TOP   = 4'd7;
    localparam logic [3:0] CNT_MAX   = 4'd15;

    typedef logic [15:0] word_t;

    typedef struct packed {
        logic [2:0] model;
        logic [4:0] rows;
        logic [4:0] cols;
    } cfg_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] row;
        logic [3:0] col;
    } entry_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] rb;
        logic [3:0] cb;
    } contact_t;

    typedef struct packed {
        logic              rd_en;
        logic [KEY_AW-1:0] rd_key;
    } tbl_rd_t;

    typedef struct packed {
        logic              wr_en;
        logic [KEY_AW-1:0] wr_key;
        logic [3:0]        row;
        logic [3:0]        col;
    } tbl_wr_t;

    function automatic word_t ones(input logic [4:0] n);
        logic [16:0] full;
        full = (17'd1 << n) - 17'd1;
        return (n >= 5'd16) ? '1 : full[15:0];
    endfunction

    function automatic word_t line_reset(input int idx, input logic [4:0] n_lines,
                                         input logic [4:0] n_bits);
        return (idx < int'(n_lines)) ? ones(n_bits) : '0;
    endfunction

    function automatic contact_t locate(input entry_t e, input logic [4:0] rows);
        logic [4:0] rb_full;
        logic [3:0] cb;
        contact_t   c;
        rb_full = rows - 5'd1 - {1'b0, e.row};
        cb      = (e.col < COL_SPLIT) ? (COL_TOP - e.col) : e.col;
        c.hit   = e.valid && ({1'b0, e.row} < rows) && (int'(rb_full) < ROW_LINES)
                  && (int'(cb) < COL_LINES);
        c.rb    = rb_full[3:0];
        c.cb    = cb;
        return c;
    endfunction

    function automatic logic [7:0] fkey_base(input logic [7:0] key, input logic alt);
        logic [7:0] b;
        case (key)
            K_F2:    b = K_F1;
            K_F4:    b = alt ? K_F1 : K_F3;
            K_F5:    b = alt ? K_F2 : K_NONE;
            K_F6:    b = alt ? K_F3 : K_F5;
            K_F8:    b = K_F7;
            default: b = K_NONE;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

/* sv/kmcm_ifs.sv */
`default_nettype none

interface kmcm_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] func;
    logic [7:0] key_id;
    logic [3:0] entry_row;
    logic [3:0] entry_col;
    logic [3:0] line_index;

    modport source (output valid, func, key_id, entry_row, entry_col, line_index,
                    input ready);
    modport sink   (input valid, func, key_id, entry_row, entry_col, line_index,
                    output ready);
endinterface

interface kmcm_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] row_word;
    logic [15:0] col_word;
    logic        restore_down;
    logic        combo_active;

    modport source (output valid, row_word, col_word, restore_down, combo_active,
                    input ready);
    modport sink   (input valid, row_word, col_word, restore_down, combo_active,
                    output ready);
endinterface

`default_nettype wire

/* sv/kmcm_cfg.sv */
`default_nettype none

module kmcm_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kmcm_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output kmcm_pkg::cfg_t                cfg
);
    import kmcm_pkg::*;

    logic [2:0] model_reg;
    logic [4:0] rows_reg;
    logic [4:0] cols_reg;
    logic [1:0] idx;
    logic       wr;

    assign idx    = paddr[3:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_reg <= RST_MODEL;
            rows_reg  <= RST_ROWS;
            cols_reg  <= RST_COLS;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_MODEL: model_reg <= pwdata[2:0];
                REG_ROWS:  rows_reg  <= pwdata[4:0];
                REG_COLS:  cols_reg  <= pwdata[4:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_MODEL: prdata = 32'(model_reg);
            REG_ROWS:  prdata = 32'(rows_reg);
            REG_COLS:  prdata = 32'(cols_reg);
            default:   prdata = '0;
        endcase
    end

    assign cfg = '{model: model_reg, rows: rows_reg, cols: cols_reg};

endmodule

`default_nettype wire

/* sv/kmcm_table.sv */
`default_nettype none

module kmcm_table (
    input  logic              clk,
    input  logic              rst_n,
    input  kmcm_pkg::tbl_rd_t rd,
    input  kmcm_pkg::tbl_wr_t wr,
    input  logic [7:0]        base_key,
    output kmcm_pkg::entry_t  key_ent,
    output kmcm_pkg::entry_t  shift_ent,
    output kmcm_pkg::entry_t  base_ent
);
    import kmcm_pkg::*;

    logic [7:0]          mem [KEY_IDS];
    logic [KEY_IDS-1:0]  vld_reg;
    logic [7:0]          rd_data_reg;
    logic                rd_vld_reg;
    logic                same_addr;

    // copies of the low key ids, read by the combo paths
    logic [7:0]          sh_data_reg [SHADOW_N];
    logic [SHADOW_N-1:0] sh_vld_reg;
    logic                sh_wr;
    logic                base_in;

    assign same_addr = wr.wr_en && (wr.wr_key == rd.rd_key);
    assign sh_wr     = wr.wr_en && (int'(wr.wr_key) < SHADOW_N);
    assign base_in   = int'(base_key) < SHADOW_N;

    always_ff @(posedge clk)
    begin
        if (wr.wr_en)
        begin
            mem[wr.wr_key] <= {wr.row, wr.col};
        end
        if (rd.rd_en)
        begin
            rd_data_reg <= same_addr ? {wr.row, wr.col} : mem[rd.rd_key];
        end
        if (sh_wr)
        begin
            sh_data_reg[wr.wr_key[SHADOW_AW-1:0]] <= {wr.row, wr.col};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
            sh_vld_reg <= '0;
        end
        else
        begin
            if (wr.wr_en)
            begin
                vld_reg[wr.wr_key] <= 1'b1;
            end
            if (rd.rd_en)
            begin
                rd_vld_reg <= vld_reg[rd.rd_key] || same_addr;
            end
            if (sh_wr)
            begin
                sh_vld_reg[wr.wr_key[SHADOW_AW-1:0]] <= 1'b1;
            end
        end
    end

    assign key_ent   = {rd_vld_reg, rd_data_reg};
    assign shift_ent = {sh_vld_reg[K_LSHIFT[SHADOW_AW-1:0]],
                        sh_data_reg[K_LSHIFT[SHADOW_AW-1:0]]};
    assign base_ent  = {base_in && sh_vld_reg[base_key[SHADOW_AW-1:0]],
                        sh_data_reg[base_key[SHADOW_AW-1:0]]};

endmodule

`default_nettype wire

/* sv/kmcm_core.sv */
`default_nettype none
`include "assert_macros.svh"

module kmcm_core (
    input  logic               clk,
    input  logic               rst_n,
    input  kmcm_pkg::cfg_t     cfg,
    kmcm_in_if.sink            cmd,
    kmcm_out_if.source         rsp,
    output kmcm_pkg::tbl_rd_t  tbl_rd,
    output kmcm_pkg::tbl_wr_t  tbl_wr,
    output logic [7:0]         base_key,
    input  kmcm_pkg::entry_t   key_ent,
    input  kmcm_pkg::entry_t   shift_ent,
    input  kmcm_pkg::entry_t   base_ent
);
    import kmcm_pkg::*;

    // input stage
    logic       s1_valid_reg;
    logic [2:0] s1_func_reg;
    logic [7:0] s1_key_reg;
    logic [3:0] s1_row_reg;
    logic [3:0] s1_col_reg;
    logic [3:0] s1_line_reg;

    // contact and flag state
    word_t      row_reg [ROW_LINES];
    word_t      col_reg [COL_LINES];
    logic       restore_reg;
    logic       left_reg;
    logic       up_reg;
    logic [3:0] count_reg;

    // result register
    logic       o_valid_reg;
    word_t      o_row_reg;
    word_t      o_col_reg;
    logic       o_restore_reg;
    logic       o_combo_reg;

    logic       acc;
    logic       adv;
    logic       key_nz;
    logic       key_in_range;
    logic       press_op;
    logic       rel_op;
    logic       load_op;
    logic       clear_op;
    logic       cursor_mdl;
    logic       alt;
    logic       is_restore;
    logic       left_c;
    logic       up_c;
    logic [7:0] fbase;
    logic [7:0] fbase2;
    logic       is_fkey;
    logic       chain;
    logic [3:0] steps;
    logic [4:0] cnt_sum;
    logic [3:0] cnt_up;
    logic [3:0] cnt_dn;
    logic [2:0] en;
    contact_t   c [3];
    logic       restore_next;
    logic       left_next;
    logic       up_next;
    logic [3:0] count_next;
    word_t      row_next [ROW_LINES];
    word_t      col_next [COL_LINES];
    word_t      mask;
    word_t      q_row;
    word_t      q_col;

    assign adv       = s1_valid_reg && (!o_valid_reg || rsp.ready);
    assign cmd.ready = !s1_valid_reg || adv;
    assign acc       = cmd.valid && cmd.ready;

    assign tbl_rd = '{rd_en: acc, rd_key: cmd.key_id[KEY_AW-1:0]};

    // decode
    always_comb
    begin
        key_nz       = s1_key_reg != K_NONE;
        key_in_range = int'(s1_key_reg) < KEY_IDS;
        press_op     = (s1_func_reg == FUNC_PRESS) && key_nz;
        rel_op       = (s1_func_reg == FUNC_RELEASE) && key_nz;
        load_op      = (s1_func_reg == FUNC_LOAD) && key_nz && key_in_range && !key_ent.valid;
        clear_op     = s1_func_reg == FUNC_CLEAR;
        cursor_mdl   = (cfg.model == MODEL_CURSOR_A) || (cfg.model == MODEL_CURSOR_B);
        alt          = cfg.model == MODEL_ALT_FKEY;
        is_restore   = s1_key_reg == K_RESTORE;
        left_c       = (s1_key_reg == K_LEFT) && cursor_mdl;
        up_c         = (s1_key_reg == K_UP) && cursor_mdl;
        fbase        = fkey_base(s1_key_reg, alt);
        fbase2       = fkey_base(fbase, alt);
        is_fkey      = fbase != K_NONE;
        chain        = is_fkey && (fbase2 != K_NONE);
        if (left_c)
            base_key = K_RIGHT;
        else if (up_c)
            base_key = K_DOWN;
        else if (chain)
            base_key = fbase2;
        else
            base_key = fbase;
        steps   = chain ? 4'd2 : 4'd1;
        cnt_sum = {1'b0, count_reg} + {1'b0, steps};
        cnt_up  = (cnt_sum > {1'b0, CNT_MAX}) ? CNT_MAX : cnt_sum[3:0];
        cnt_dn  = (count_reg > steps) ? (count_reg - steps) : 4'd0;
    end

    // flags and which contacts move
    always_comb
    begin
        restore_next = restore_reg;
        left_next    = left_reg;
        up_next      = up_reg;
        count_next   = count_reg;
        en           = 3'b000;
        if (press_op)
        begin
            if (is_restore)
                restore_next = 1'b1;
            else if (left_c)
            begin
                left_next = 1'b1;
                en        = 3'b110;
            end
            else if (up_c)
            begin
                up_next = 1'b1;
                en      = 3'b110;
            end
            else if (is_fkey)
            begin
                count_next = cnt_up;
                en         = 3'b110;
            end
            else
                en = {2'b00, key_in_range};
        end
        else if (rel_op)
        begin
            if (is_restore)
                restore_next = 1'b0;
            else if (left_c)
            begin
                en[2] = 1'b1;
                if (left_reg)
                begin
                    left_next = 1'b0;
                    en[1]     = !(up_reg || (count_reg != 4'd0));
                end
            end
            else if (up_c)
            begin
                en[2] = 1'b1;
                if (up_reg)
                begin
                    up_next = 1'b0;
                    en[1]   = !(left_reg || (count_reg != 4'd0));
                end
            end
            else if (is_fkey)
            begin
                en[2] = 1'b1;
                if (count_reg != 4'd0)
                begin
                    count_next = cnt_dn;
                    en[1]      = (cnt_dn == 4'd0) && !left_reg && !up_reg;
                end
            end
            else
                en = {2'b00, key_in_range};
        end
        else if (clear_op)
        begin
            restore_next = 1'b0;
            left_next    = 1'b0;
            up_next      = 1'b0;
            count_next   = 4'd0;
        end
    end

    assign c[0] = locate(key_ent, cfg.rows);
    assign c[1] = locate(shift_ent, cfg.rows);
    assign c[2] = locate(base_ent, cfg.rows);

    // contact words after the item
    always_comb
    begin
        for (int r = 0; r < ROW_LINES; r++)
        begin
            mask = '0;
            for (int i = 0; i < 3; i++)
            begin
                if (en[i] && c[i].hit && (int'(c[i].rb) == r))
                    mask = mask | (word_t'(1) << c[i].cb);
            end
            if (clear_op)
                row_next[r] = line_reset(r, cfg.rows, cfg.cols);
            else if (press_op)
                row_next[r] = row_reg[r] & ~mask;
            else
                row_next[r] = row_reg[r] | mask;
        end
        for (int k = 0; k < COL_LINES; k++)
        begin
            mask = '0;
            for (int i = 0; i < 3; i++)
            begin
                if (en[i] && c[i].hit && (int'(c[i].cb) == k))
                    mask = mask | (word_t'(1) << c[i].rb);
            end
            if (clear_op)
                col_next[k] = line_reset(k, cfg.cols, cfg.rows);
            else if (press_op)
                col_next[k] = col_reg[k] & ~mask;
            else
                col_next[k] = col_reg[k] | mask;
        end
        q_row = (int'(s1_line_reg) < ROW_LINES) ? row_next[s1_line_reg] : '0;
        q_col = (int'(s1_line_reg) < COL_LINES) ? col_next[s1_line_reg] : '0;
    end

    assign tbl_wr = '{wr_en: adv && load_op, wr_key: s1_key_reg[KEY_AW-1:0],
                      row: s1_row_reg, col: s1_col_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (acc)
            s1_valid_reg <= 1'b1;
        else if (adv)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_func_reg <= cmd.func;
            s1_key_reg  <= cmd.key_id;
            s1_row_reg  <= cmd.entry_row;
            s1_col_reg  <= cmd.entry_col;
            s1_line_reg <= cmd.line_index;
        end
        if (adv)
        begin
            o_row_reg     <= q_row;
            o_col_reg     <= q_col;
            o_restore_reg <= restore_next;
            o_combo_reg   <= left_next || up_next || (count_next != 4'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < ROW_LINES; r++)
                row_reg[r] <= line_reset(r, RST_ROWS, RST_COLS);
            for (int k = 0; k < COL_LINES; k++)
                col_reg[k] <= line_reset(k, RST_COLS, RST_ROWS);
            restore_reg <= 1'b0;
            left_reg    <= 1'b0;
            up_reg      <= 1'b0;
            count_reg   <= 4'd0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                row_reg     <= row_next;
                col_reg     <= col_next;
                restore_reg <= restore_next;
                left_reg    <= left_next;
                up_reg      <= up_next;
                count_reg   <= count_next;
            end
            if (adv)
                o_valid_reg <= 1'b1;
            else if (rsp.ready)
                o_valid_reg <= 1'b0;
        end
    end

    assign rsp.valid        = o_valid_reg;
    assign rsp.row_word     = o_row_reg;
    assign rsp.col_word     = o_col_reg;
    assign rsp.restore_down = o_restore_reg;
    assign rsp.combo_active = o_combo_reg;

    `KMCM_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |-> !o_valid_reg && !s1_valid_reg, "pipe not empty in reset")
    `KMCM_ASSERT(a_combo_match, clk, rst_n, adv |=> o_combo_reg == (left_reg || up_reg || (count_reg != 4'd0)), "combo flag out of step")
    `KMCM_ASSERT(a_restore_match, clk, rst_n, adv |=> o_restore_reg == restore_reg, "restore flag out of step")
    `KMCM_ASSERT(a_no_overrun, clk, rst_n, o_valid_reg && !rsp.ready |-> !adv, "result overwritten while stalled")

endmodule

`default_nettype wire

/* sv/keyboard_matrix_contact_mapper_top.sv */
`default_nettype none
// channel  | dir | handshake       | payload
// cmd      | in  | valid / ready   | func, key_id, entry_row, entry_col, line_index
// rsp      | out | valid / ready   | row_word, col_word, restore_down, combo_active
// apb      | in  | psel / penable  | paddr, pwdata, prdata (pready tied high)
//
// one item per cycle while rsp is ready; an accepted item passes the input stage, then the output register, to rsp
// the registered key table read feeds one compute stage, which loads the output register
// reset opens the 8 x 8 contact pattern and marks every table entry invalid at once
// a stalled result holds in the output register, one more item waits in the input stage

module keyboard_matrix_contact_mapper_top (
    input  logic                         clk,
    input  logic                         rst_n,
    kmcm_in_if.sink                      cmd,
    kmcm_out_if.source                   rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [kmcm_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import kmcm_pkg::*;

    cfg_t       cfg;
    tbl_rd_t    tbl_rd;
    tbl_wr_t    tbl_wr;
    logic [7:0] base_key;
    entry_t     key_ent;
    entry_t     shift_ent;
    entry_t     base_ent;

    kmcm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    kmcm_table u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd        (tbl_rd),
        .wr        (tbl_wr),
        .base_key  (base_key),
        .key_ent   (key_ent),
        .shift_ent (shift_ent),
        .base_ent  (base_ent)
    );

    kmcm_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .rsp       (rsp),
        .tbl_rd    (tbl_rd),
        .tbl_wr    (tbl_wr),
        .base_key  (base_key),
        .key_ent   (key_ent),
        .shift_ent (shift_ent),
        .base_ent  (base_ent)
    );

endmodule

`default_nettype wire

/* sim/keyboard_matrix_contact_mapper_top_tb.sv */
`timescale 1ns / 1ps

module keyboard_matrix_contact_mapper_top_tb;

    import kmcm_pkg::*;

    localparam logic [2:0] FUNC_UNUSED_LO = 3'd5;
    localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;
    localparam int STALL_LIMIT = 2000;
    localparam int DIRECTED_N = 25;
    localparam int PHASES = 10;
    localparam int PHASE_ITEMS = 108;
    localparam logic [33:0] NO_REPORT = '0;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] key;
        logic [3:0] erow;
        logic [3:0] ecol;
        logic [3:0] line;
    } key_event_t;

    typedef struct packed {
        word_t row_word;
        word_t col_word;
        logic  restore_down;
        logic  combo_active;
    } contact_report_t;

    typedef struct packed {
        key_event_t      ev;
        logic            fixed;
        contact_report_t rep;
    } directed_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    kmcm_in_if  cmd_if();
    kmcm_out_if rsp_if();

    keyboard_matrix_contact_mapper_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_if),
        .rsp     (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 clk = ~clk;

    // predicted block state
    cfg_t            layout_q;
    word_t           row_mx [ROW_LINES];
    word_t           col_mx [COL_LINES];
    entry_t          key_map [KEY_IDS];
    logic            restore_q;
    logic            left_q;
    logic            up_q;
    logic [3:0]      fcount;

    contact_report_t pending_reports [$];
    contact_report_t seen_exp;
    directed_row_t   directed_tab [DIRECTED_N];
    cfg_t            phase_cfg [8];
    int              mismatches = 0;
    int              burst_left = 0;
    logic [15:0]     stall_pat = 16'hFFFF;
    logic [6:0]      ready_tick = '0;

    function automatic word_t line_mask(input logic [4:0] n);
        logic [16:0] t;
        t = (17'd1 << n) - 17'd1;
        if (n >= 5'd16)
        begin
            return 16'hFFFF;
        end
        return t[15:0];
    endfunction

    function automatic void open_matrix();
        for (int i = 0; i < ROW_LINES; i++)
        begin
            row_mx[i] = (i < int'(layout_q.rows)) ? line_mask(layout_q.cols) : '0;
        end
        for (int i = 0; i < COL_LINES; i++)
        begin
            col_mx[i] = (i < int'(layout_q.cols)) ? line_mask(layout_q.rows) : '0;
        end
    endfunction

    function automatic bit cursor_model();
        return layout_q.model == MODEL_CURSOR_A || layout_q.model == MODEL_CURSOR_B;
    endfunction

    function automatic bit combo_any();
        return left_q || up_q || fcount != 4'd0;
    endfunction

    function automatic logic [7:0] fkey_target(input logic [7:0] key);
        logic alt;
        alt = (layout_q.model == MODEL_ALT_FKEY);
        case (key)
            K_F2:    return K_F1;
            K_F4:    return alt ? K_F1 : K_F3;
            K_F5:    return alt ? K_F2 : K_NONE;
            K_F6:    return alt ? K_F3 : K_F5;
            K_F8:    return K_F7;
            default: return K_NONE;
        endcase
    endfunction

    // row position reversed within the active rows, columns 0 to 7 reversed, 1 means open
    function automatic void touch(input logic [7:0] key, input bit closed);
        entry_t     e;
        logic [4:0] rb;
        logic [3:0] cb;
        e = key_map[key];
        rb = layout_q.rows - 5'd1 - {1'b0, e.row};
        if (!e.valid || {1'b0, e.row} >= layout_q.rows || rb >= 5'd16)
        begin
            return;
        end
        cb = (e.col < COL_SPLIT) ? (COL_TOP - e.col) : e.col;
        row_mx[rb[3:0]][cb] = !closed;
        col_mx[cb][rb[3:0]] = !closed;
    endfunction

    function automatic void press_key(input logic [7:0] key);
        logic [7:0] tgt;
        tgt = fkey_target(key);
        if (key == K_RESTORE)
        begin
            restore_q = 1'b1;
        end
        else if (key == K_LEFT && cursor_model())
        begin
            left_q = 1'b1;
            press_key(K_LSHIFT);
            press_key(K_RIGHT);
        end
        else if (key == K_UP && cursor_model())
        begin
            up_q = 1'b1;
            press_key(K_LSHIFT);
            press_key(K_DOWN);
        end
        else if (tgt != K_NONE)
        begin
            if (fcount != CNT_MAX)
            begin
                fcount = fcount + 4'd1;
            end
            press_key(K_LSHIFT);
            press_key(tgt);
        end
        else
        begin
            touch(key, 1'b1);
        end
    endfunction

    function automatic void key_up(input logic [7:0] key);
        logic [7:0] tgt;
        tgt = fkey_target(key);
        if (key == K_RESTORE)
        begin
            restore_q = 1'b0;
        end
        else if (key == K_LEFT && cursor_model())
        begin
            key_up(K_RIGHT);
            if (left_q)
            begin
                left_q = 1'b0;
                if (!combo_any())
                begin
                    key_up(K_LSHIFT);
                end
            end
        end
        else if (key == K_UP && cursor_model())
        begin
            key_up(K_DOWN);
            if (up_q)
            begin
                up_q = 1'b0;
                if (!combo_any())
                begin
                    key_up(K_LSHIFT);
                end
            end
        end
        else if (tgt != K_NONE)
        begin
            key_up(tgt);
            if (fcount != 4'd0)
            begin
                fcount = fcount - 4'd1;
                if (!combo_any())
                begin
                    key_up(K_LSHIFT);
                end
            end
        end
        else
        begin
            touch(key, 1'b0);
        end
    endfunction

    function automatic contact_report_t apply_item(input key_event_t ev);
        contact_report_t rep;
        case (ev.func)
            FUNC_PRESS:
            begin
                if (ev.key != K_NONE)
                begin
                    press_key(ev.key);
                end
            end
            FUNC_RELEASE:
            begin
                if (ev.key != K_NONE)
                begin
                    key_up(ev.key);
                end
            end
            FUNC_LOAD:
            begin
                if (ev.key != K_NONE && !key_map[ev.key].valid)
                begin
                    key_map[ev.key] = {1'b1, ev.erow, ev.ecol};
                end
            end
            FUNC_CLEAR:
            begin
                open_matrix();
                restore_q = 1'b0;
                left_q = 1'b0;
                up_q = 1'b0;
                fcount = 4'd0;
            end
            default:
            begin
            end
        endcase
        rep.row_word = row_mx[ev.line];
        rep.col_word = col_mx[ev.line];
        rep.restore_down = restore_q;
        rep.combo_active = combo_any();
        return rep;
    endfunction

    function automatic logic [7:0] random_key();
        int kp;
        kp = $urandom_range(0, 9);
        if (kp < 6)
        begin
            return 8'($urandom_range(K_F8, K_RESTORE));
        end
        else if (kp < 8)
        begin
            return 8'($urandom_range(31, K_F8 + 8'd1));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic key_event_t random_event(input bit storm);
        key_event_t ev;
        int         pick;
        ev.erow = 4'($urandom_range(0, 15));
        ev.ecol = 4'($urandom_range(0, 15));
        ev.line = 4'($urandom_range(0, 15));
        ev.key = random_key();
        pick = $urandom_range(0, 99);
        if (storm)
        begin
            // hold F-keys down to push the shift counter to its top
            ev.key = 8'($urandom_range(K_F8, K_F1));
            ev.func = (pick < 85) ? FUNC_PRESS : FUNC_RELEASE;
        end
        else if (pick < 34)
        begin
            ev.func = FUNC_PRESS;
        end
        else if (pick < 64)
        begin
            ev.func = FUNC_RELEASE;
        end
        else if (pick < 76)
        begin
            ev.func = FUNC_LOAD;
        end
        else if (pick < 79)
        begin
            ev.func = FUNC_CLEAR;
        end
        else if (pick < 94)
        begin
            ev.func = FUNC_QUERY;
        end
        else
        begin
            ev.func = 3'($urandom_range(FUNC_UNUSED_HI, FUNC_UNUSED_LO));
        end
        return ev;
    endfunction

    task automatic note_mismatch(input string what, input word_t e, input word_t a);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%0t: %s expected %h actual %h", $time, what, e, a);
        end
    endtask

    task automatic send_item(input key_event_t ev, input bit fixed, input contact_report_t typed);
        contact_report_t rep;
        @(negedge clk);
        cmd_if.valid      <= 1'b1;
        cmd_if.func       <= ev.func;
        cmd_if.key_id     <= ev.key;
        cmd_if.entry_row  <= ev.erow;
        cmd_if.entry_col  <= ev.ecol;
        cmd_if.line_index <= ev.line;
        @(posedge clk);
        while (!cmd_if.ready)
        begin
            @(posedge clk);
        end
        rep = apply_item(ev);
        pending_reports.push_back(fixed ? typed : rep);
    endtask

    task automatic pace();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(1, 6);
            @(negedge clk);
            cmd_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        cmd_if.valid <= 1'b0;
        while (pending_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        case (idx)
            REG_MODEL: layout_q.model = val[2:0];
            REG_ROWS:  layout_q.rows = val[4:0];
            REG_COLS:  layout_q.cols = val[4:0];
            default:
            begin
            end
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // receiver stall pattern, reshuffled each time the 7-bit ready_tick counter wraps
    always @(negedge clk)
    begin
        ready_tick <= ready_tick + 7'd1;
        if (ready_tick == 7'd0)
        begin
            case ($urandom_range(0, 3))
                0:       stall_pat <= 16'hFFFF;
                1:       stall_pat <= 16'h1111;
                2:       stall_pat <= 16'hF0F3;
                default: stall_pat <= 16'($urandom) | 16'h0001;
            endcase
        end
        rsp_if.ready <= stall_pat[ready_tick[3:0]];
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_reports.size() == 0)
            begin
                note_mismatch("result with nothing pending, row_word", '0, rsp_if.row_word);
            end
            else
            begin
                seen_exp = pending_reports.pop_front();
                if (rsp_if.row_word !== seen_exp.row_word)
                begin
                    note_mismatch("row_word", seen_exp.row_word, rsp_if.row_word);
                end
                if (rsp_if.col_word !== seen_exp.col_word)
                begin
                    note_mismatch("col_word", seen_exp.col_word, rsp_if.col_word);
                end
                if (rsp_if.restore_down !== seen_exp.restore_down)
                begin
                    note_mismatch("restore_down", word_t'(seen_exp.restore_down),
                                  word_t'(rsp_if.restore_down));
                end
                if (rsp_if.combo_active !== seen_exp.combo_active)
                begin
                    note_mismatch("combo_active", word_t'(seen_exp.combo_active),
                                  word_t'(rsp_if.combo_active));
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin : main_seq
        cfg_t pc;
        int   storm_left;

        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cmd_if.valid = 1'b0;
        cmd_if.func = FUNC_QUERY;
        cmd_if.key_id = K_NONE;
        cmd_if.entry_row = '0;
        cmd_if.entry_col = '0;
        cmd_if.line_index = '0;

        layout_q = {RST_MODEL, RST_ROWS, RST_COLS};
        for (int i = 0; i < KEY_IDS; i++)
        begin
            key_map[i] = '0;
        end
        open_matrix();
        restore_q = 1'b0;
        left_q = 1'b0;
        up_q = 1'b0;
        fcount = 4'd0;

        // func, key, row, col, line, fixed, row_word, col_word, restore, combo
        directed_tab[0]  = {FUNC_QUERY, K_NONE, 4'd0, 4'd0, 4'd0,
                            1'b1, 16'h00FF, 16'h00FF, 1'b0, 1'b0};
        directed_tab[1]  = {FUNC_QUERY, K_NONE, 4'd0, 4'd0, 4'd15,
                            1'b1, 16'h0000, 16'h0000, 1'b0, 1'b0};
        directed_tab[2]  = {FUNC_UNUSED_HI, 8'hFF, 4'd15, 4'd15, 4'd8,
                            1'b1, 16'h0000, 16'h0000, 1'b0, 1'b0};
        directed_tab[3]  = {FUNC_PRESS, K_RESTORE, 4'd0, 4'd0, 4'd0,
                            1'b1, 16'h00FF, 16'h00FF, 1'b1, 1'b0};
        directed_tab[4]  = {FUNC_RELEASE, K_RESTORE, 4'd0, 4'd0, 4'd0,
                            1'b1, 16'h00FF, 16'h00FF, 1'b0, 1'b0};
        directed_tab[5]  = {FUNC_LOAD, K_NONE, 4'd0, 4'd0, 4'd0, 1'b0, NO_REPORT};
        directed_tab[6]  = {FUNC_LOAD, K_LSHIFT, 4'd1, 4'd7, 4'd6, 1'b0, NO_REPORT};
        directed_tab[7]  = {FUNC_LOAD, K_RIGHT, 4'd0, 4'd2, 4'd7, 1'b0, NO_REPORT};
        directed_tab[8]  = {FUNC_LOAD, K_DOWN, 4'd0, 4'd7, 4'd0, 1'b0, NO_REPORT};
        directed_tab[9]  = {FUNC_LOAD, K_RIGHT, 4'd5, 4'd5, 4'd0, 1'b0, NO_REPORT};
        directed_tab[10] = {FUNC_LOAD, K_F1, 4'd2, 4'd8, 4'd8, 1'b0, NO_REPORT};
        directed_tab[11] = {FUNC_LOAD, K_F3, 4'd3, 4'd15, 4'd15, 1'b0, NO_REPORT};
        directed_tab[12] = {FUNC_LOAD, 8'hFF, 4'd15, 4'd15, 4'd0, 1'b0, NO_REPORT};
        directed_tab[13] = {FUNC_PRESS, K_NONE, 4'd0, 4'd0, 4'd0, 1'b0, NO_REPORT};
        directed_tab[14] = {FUNC_PRESS, 8'hC8, 4'd0, 4'd0, 4'd0, 1'b0, NO_REPORT};
        directed_tab[15] = {FUNC_PRESS, 8'hFF, 4'd0, 4'd0, 4'd0, 1'b0, NO_REPORT};
        directed_tab[16] = {FUNC_PRESS, K_LEFT, 4'd0, 4'd0, 4'd7, 1'b0, NO_REPORT};
        directed_tab[17] = {FUNC_PRESS, K_UP, 4'd0, 4'd0, 4'd6, 1'b0, NO_REPORT};
        directed_tab[18] = {FUNC_RELEASE, K_LEFT, 4'd0, 4'd0, 4'd6, 1'b0, NO_REPORT};
        directed_tab[19] = {FUNC_RELEASE, K_UP, 4'd0, 4'd0, 4'd7, 1'b0, NO_REPORT};
        directed_tab[20] = {FUNC_PRESS, K_F4, 4'd0, 4'd0, 4'd4, 1'b0, NO_REPORT};
        directed_tab[21] = {FUNC_PRESS, K_F2, 4'd0, 4'd0, 4'd5, 1'b0, NO_REPORT};
        directed_tab[22] = {FUNC_RELEASE, K_F2, 4'd0, 4'd0, 4'd6, 1'b0, NO_REPORT};
        directed_tab[23] = {FUNC_RELEASE, K_F4, 4'd0, 4'd0, 4'd15, 1'b0, NO_REPORT};
        directed_tab[24] = {FUNC_CLEAR, K_NONE, 4'd0, 4'd0, 4'd7,
                            1'b1, 16'h00FF, 16'h00FF, 1'b0, 1'b0};

        phase_cfg[0] = {MODEL_ALT_FKEY, 5'd16, 5'd16};
        phase_cfg[1] = {3'd0, 5'd1, 5'd1};
        phase_cfg[2] = {MODEL_CURSOR_B, 5'd16, 5'd1};
        phase_cfg[3] = {MODEL_ALT_FKEY, 5'd1, 5'd16};
        phase_cfg[4] = {MODEL_CURSOR_A, 5'd16, 5'd16};
        phase_cfg[5] = {3'd3, 5'd5, 5'd12};
        phase_cfg[6] = {3'd5, 5'd16, 5'd8};
        phase_cfg[7] = {3'd6, 5'd3, 5'd3};

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_N; i++)
        begin
            send_item(directed_tab[i].ev, directed_tab[i].fixed, directed_tab[i].rep);
            pace();
        end

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            if (p < 8)
            begin
                pc = phase_cfg[p];
            end
            else
            begin
                pc.model = 3'($urandom_range(0, 6));
                pc.rows = 5'($urandom_range(1, 16));
                pc.cols = 5'($urandom_range(1, 16));
            end
            write_reg(REG_MODEL, {29'd0, pc.model});
            write_reg(REG_ROWS, {27'd0, pc.rows});
            write_reg(REG_COLS, {27'd0, pc.cols});
            if ($urandom_range(0, 1) == 1)
            begin
                send_item({FUNC_CLEAR, K_NONE, 4'd0, 4'd0, 4'd0}, 1'b0, NO_REPORT);
            end
            storm_left = 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (storm_left == 0 && $urandom_range(0, 39) == 0)
                begin
                    storm_left = 60;
                end
                if ($urandom_range(0, 299) == 0)
                begin
                    drain();
                end
                send_item(random_event(storm_left != 0), 1'b0, NO_REPORT);
                if (storm_left > 0)
                begin
                    storm_left--;
                end
                pace();
            end
        end

        drain();
        if (mismatches == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* keyboard_matrix_contact_mapper_top.f */
+incdir+sv
sv/kmcm_pkg.sv
sv/kmcm_ifs.sv
sv/kmcm_cfg.sv
sv/kmcm_table.sv
sv/kmcm_core.sv
sv/keyboard_matrix_contact_mapper_top.sv
sim/keyboard_matrix_contact_mapper_top_tb.sv
